FILE: hdl/sm4_pkg.sv
// sm4_pkg: shared types, codes, s-box table and round function for the sm4 engine
// no dependencies; imported by sm4_ctrl, sm4_dpath and the top unit (sm4_ram does not use it)
package sm4_pkg;

    localparam int NUM_ROUNDS   = 32;
    localparam int ROUND_W      = $clog2(NUM_ROUNDS);
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 64;

    localparam logic OP_LOAD_KEY = 1'b0;
    localparam logic OP_BLOCK    = 1'b1;

    localparam logic MODE_ECB    = 1'b0;
    localparam logic MODE_CTR32  = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_MODE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IV_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IV_LOW  = 2'd2;

    typedef struct packed {
        logic                operation;
        logic [ROUND_W-1:0]  key_index;
        logic [31:0]         key_word;
        logic [63:0]         block_high;
        logic [63:0]         block_low;
    } sm4_in_t;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } sm4_out_t;

    typedef struct packed {
        logic start;
        logic round;
        logic load_out;
    } sm4_cmd_t;

    localparam logic [7:0] SBOX [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    // byte-wise s-box followed by the linear transform
    function automatic logic [31:0] t_transform(input logic [31:0] a);
        logic [31:0] b;
        b = {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
        return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
                 ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
    endfunction

endpackage

FILE: hdl/sm4_ram.sv
// sm4_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module sm4_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/sm4_ctrl.sv
// sm4_ctrl: state machine sequencing key loads, 32 rounds and result hand-off
// depends on sm4_pkg
module sm4_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_ready,
    input  logic                    req_operation,
    output logic                    rsp_valid,
    input  logic                    rsp_ready,
    output logic                    key_we,
    output logic [sm4_pkg::ROUND_W-1:0] key_raddr,
    output sm4_pkg::sm4_cmd_t       cmd
);
    import sm4_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_ROUND  = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic               rsp_valid_reg, rsp_valid_next;
    logic               req_accept;
    logic               last_round;

    assign req_ready  = (state_reg == ST_IDLE);
    assign req_accept = req_valid && req_ready;
    assign last_round = (round_reg == ROUND_W'(NUM_ROUNDS - 1));
    assign rsp_valid  = rsp_valid_reg;
    assign key_we     = req_accept && (req_operation == OP_LOAD_KEY);

    always_comb
    begin
        state_next     = state_reg;
        round_next     = round_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        cmd            = '0;
        key_raddr      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_accept && (req_operation == OP_BLOCK))
                begin
                    cmd.start  = 1'b1;
                    round_next = '0;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                cmd.round  = 1'b1;
                key_raddr  = round_reg + 1'b1;
                round_next = round_reg + 1'b1;
                if (last_round)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.load_out   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            round_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    a_last_round_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) && last_round |=> (state_reg == ST_FINISH))
        else $error("round sequence did not end after the last round");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!rsp_valid_reg || rsp_ready))
        else $error("pending result overwritten");

    a_block_starts: assert property (@(posedge clk) disable iff (!rst_n)
        req_accept && (req_operation == OP_BLOCK) |=>
            (state_reg == ST_ROUND) && (round_reg == '0))
        else $error("block word did not start at round zero");

    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> !req_ready && !key_we)
        else $error("input taken while rounds in progress");

endmodule

FILE: hdl/sm4_dpath.sv
// sm4_dpath: configuration registers, counter, round state and result register
// depends on sm4_pkg
module sm4_dpath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [sm4_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sm4_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  sm4_pkg::sm4_in_t                req_word,
    input  logic [31:0]                     round_key,
    input  sm4_pkg::sm4_cmd_t               cmd,
    output sm4_pkg::sm4_out_t               rsp_word
);
    import sm4_pkg::*;

    logic         mode_reg;
    logic [63:0]  iv_high_reg;
    logic [63:0]  iv_low_reg;
    logic [31:0]  ctr_reg, ctr_next;
    logic [31:0]  x0_reg, x1_reg, x2_reg, x3_reg;
    logic [127:0] mask_reg;
    logic [127:0] out_reg;
    logic [31:0]  new_word;

    assign new_word = x0_reg ^ t_transform(x1_reg ^ x2_reg ^ x3_reg ^ round_key);

    always_comb
    begin
        ctr_next = ctr_reg;
        if (cfg_we && (cfg_index == CFG_IV_LOW))
        begin
            ctr_next = cfg_wdata[31:0];
        end
        else if (cmd.start && (mode_reg == MODE_CTR32))
        begin
            ctr_next = ctr_reg + 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_ECB;
            iv_high_reg <= '0;
            iv_low_reg  <= '0;
            ctr_reg     <= '0;
        end
        else
        begin
            ctr_reg <= ctr_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MODE:    mode_reg    <= cfg_wdata[0];
                    CFG_IV_HIGH: iv_high_reg <= cfg_wdata;
                    CFG_IV_LOW:  iv_low_reg  <= cfg_wdata;
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            if (mode_reg == MODE_CTR32)
            begin
                x0_reg   <= iv_high_reg[63:32];
                x1_reg   <= iv_high_reg[31:0];
                x2_reg   <= iv_low_reg[63:32];
                x3_reg   <= ctr_reg;
                mask_reg <= {req_word.block_high, req_word.block_low};
            end
            else
            begin
                x0_reg   <= req_word.block_high[63:32];
                x1_reg   <= req_word.block_high[31:0];
                x2_reg   <= req_word.block_low[63:32];
                x3_reg   <= req_word.block_low[31:0];
                mask_reg <= '0;
            end
        end
        else if (cmd.round)
        begin
            x0_reg <= x1_reg;
            x1_reg <= x2_reg;
            x2_reg <= x3_reg;
            x3_reg <= new_word;
        end
        if (cmd.load_out)
        begin
            // output words in reversed order
            out_reg <= {x3_reg, x2_reg, x1_reg, x0_reg} ^ mask_reg;
        end
    end

    assign rsp_word.result_high = out_reg[127:64];
    assign rsp_word.result_low  = out_reg[63:0];

endmodule

FILE: hdl/sm4_block_cipher_ecb_ctr32_unit.sv
// sm4_block_cipher_ecb_ctr32_unit: sm4 encryption engine, ecb or ctr32, 32 stored round keys
// depends on sm4_pkg, sm4_ram, sm4_ctrl, sm4_dpath
//
//  channel  | signals                        | word
//  ---------+--------------------------------+--------------------------------
//  req      | req_valid, req_ready, req_word | key load or 128-bit block
//  rsp      | rsp_valid, rsp_ready, rsp_word | 128-bit result, one per block
//  cfg      | cfg_we, cfg_index, cfg_wdata   | mode, iv_high, iv_low writes
//
// a key load is written to the key store when accepted; a block goes through accept, 32 rounds, hand-off
// one round per cycle, set by the single round unit and one key read per cycle
// the result register lets the next word in while a result waits on rsp_ready
// a finished block waits in hand-off until the previous result is taken
// reset clears control, mode, iv and counter; the key store is not cleared
module sm4_block_cipher_ecb_ctr32_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  sm4_pkg::sm4_in_t                req_word,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output sm4_pkg::sm4_out_t               rsp_word,
    input  logic                            cfg_we,
    input  logic [sm4_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sm4_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import sm4_pkg::*;

    sm4_cmd_t           cmd;
    logic               key_we;
    logic [ROUND_W-1:0] key_raddr;
    logic [31:0]        round_key;

    sm4_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req_operation (req_word.operation),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .key_we        (key_we),
        .key_raddr     (key_raddr),
        .cmd           (cmd)
    );

    sm4_ram #(
        .WIDTH (32),
        .DEPTH (NUM_ROUNDS)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (req_word.key_index),
        .wdata (req_word.key_word),
        .raddr (key_raddr),
        .rdata (round_key)
    );

    sm4_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req_word  (req_word),
        .round_key (round_key),
        .cmd       (cmd),
        .rsp_word  (rsp_word)
    );

endmodule
